// ===== rtl/sga_pkg.sv =====
// Package for the softened gravity accelerator.
// Holds field widths, codes, register reset values, the body record and the sequencer states.
// Depends on nothing; every rtl file imports it.
package sga_pkg;

  // Field and datapath widths.
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int WORD_W    = 32;
  localparam int OUT_W     = 48;
  localparam int SUMSQ_W   = 66;
  localparam int S_W       = 50;
  localparam int ROOT_IN_W = 64;
  localparam int Q_W       = 32;
  localparam int DEN_W     = 82;
  localparam int NUM_W     = 87;
  localparam int QUO_W     = 60;
  localparam int ACC_W     = 72;
  localparam int PROD_W    = 104;
  localparam int VAL_W     = PROD_W - 16;

  // Fixed-point shifts.
  localparam int SUM_SHIFT  = 16;
  localparam int SQRT_SHIFT = 14;
  localparam int NUM_SHIFT  = 23;

  // Item action codes.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_BODY_COUNT   = 2'd0,
    REG_SOFTENING_SQ = 2'd1,
    REG_GRAVITY      = 2'd2
  } cfg_reg_t;

  // Register reset values.
  localparam logic [CNT_W-1:0]  BODY_COUNT_RST   = 11'd1;
  localparam logic [WORD_W-1:0] SOFTENING_SQ_RST = 32'd655;
  localparam logic [WORD_W-1:0] GRAVITY_RST      = 32'd65536;

  // Saturation limits of the 48-bit result magnitude.
  localparam logic [VAL_W-1:0] LIMIT_POS = VAL_W'(48'h7FFF_FFFF_FFFF);
  localparam logic [VAL_W-1:0] LIMIT_NEG = VAL_W'(48'h8000_0000_0000);

  // One stored body.
  typedef struct packed {
    logic [WORD_W-1:0] mass;
    logic [WORD_W-1:0] pos_x;
    logic [WORD_W-1:0] pos_y;
    logic [WORD_W-1:0] pos_z;
  } body_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD_I,
    ST_READ_J,
    ST_LOAD_J,
    ST_SQ_ISSUE,
    ST_SQ_ACC,
    ST_SUM_S,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_DEN_ISSUE,
    ST_DEN_ACC,
    ST_NUM_ISSUE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_NEXT,
    ST_FIN_ISSUE,
    ST_FIN_ACC,
    ST_FIN_SAT,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/softened_gravity_accel.sv =====
// Channel  | ports                                          | direction | flow
// input    | start, busy, in_action .. in_pos_z             | in        | start & !busy
// result   | out_valid, out_result_index .. out_saturated   | out       | one-cycle strobe
// config   | cfg_wr_en, cfg_index, cfg_data                 | in        | write when enabled
//
// A load item is written to the body store at once; busy stays low.
// A query stays busy while it sums over n = min(body_count, MAX_BODIES) bodies, and a
// pair whose softened distance is zero skips the square root and the divisions. Each
// body pair goes through the shared 32x32 multiplier, a square root and three
// divisions, one per axis.
// Reset (rst_n low, synchronous) clears control and restores the registers.
// The result is shown for one cycle with out_valid; the receiver cannot stall.
module softened_gravity_accel import sga_pkg::*; #(
  parameter int MAX_BODIES = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_action,
  input  logic [IDX_W-1:0]         in_body_index,
  input  logic [WORD_W-1:0]        in_mass,
  input  logic signed [WORD_W-1:0] in_pos_x,
  input  logic signed [WORD_W-1:0] in_pos_y,
  input  logic signed [WORD_W-1:0] in_pos_z,
  output logic                     out_valid,
  output logic [IDX_W-1:0]         out_result_index,
  output logic signed [OUT_W-1:0]  out_acc_x,
  output logic signed [OUT_W-1:0]  out_acc_y,
  output logic signed [OUT_W-1:0]  out_acc_z,
  output logic                     out_saturated,
  input  logic                     cfg_wr_en,
  input  logic [1:0]               cfg_index,
  input  logic [WORD_W-1:0]        cfg_data
);

  localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;

  // Configuration registers.
  logic [CNT_W-1:0]  body_count_r;
  logic [WORD_W-1:0] soft_r, grav_r;

  // Sequencer and datapath registers.
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    j_r, j_nxt;
  logic [1:0]          ax_r, ax_nxt, k_r, k_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [WORD_W-1:0]   pi_r [3];
  logic [WORD_W-1:0]   pi_nxt [3];
  logic [WORD_W-1:0]   mass_r, mass_nxt;
  logic [WORD_W-1:0]   mag_r [3];
  logic [WORD_W-1:0]   mag_nxt [3];
  logic                neg_r [3];
  logic                neg_nxt [3];
  logic [SUMSQ_W-1:0]  sumsq_r, sumsq_nxt;
  logic [S_W-1:0]      s_r, s_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [ACC_W-1:0]    acc_r [3];
  logic [ACC_W-1:0]    acc_nxt [3];
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [OUT_W-1:0]    res_r [3];
  logic [OUT_W-1:0]    res_nxt [3];
  logic                sat_r, sat_nxt;

  // Unit connections.
  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  body_t               mem_wdata, mem_rdata;
  logic [WORD_W-1:0]   mul_a, mul_b;
  logic [2*WORD_W-1:0] mul_p;
  logic                sqrt_start, sqrt_done;
  logic [Q_W-1:0]      root;
  logic                div_start, div_done;
  logic [QUO_W-1:0]    quo;

  // Helpers.
  logic [CNT_W-1:0]    n_lim;
  logic                accept, idx_in_store;
  logic [ACC_W-1:0]    facc, fmag;
  logic                fneg;

  assign accept       = start && !busy;
  assign idx_in_store = 32'(idx_r) < MAX_BODIES;
  assign n_lim        = (32'(body_count_r) > MAX_BODIES) ? CNT_W'(MAX_BODIES) : body_count_r;
  assign facc         = acc_r[ax_r];
  assign fneg         = facc[ACC_W-1];
  assign fmag         = fneg ? (~facc + ACC_W'(1)) : facc;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_count_r <= BODY_COUNT_RST;
      soft_r       <= SOFTENING_SQ_RST;
      grav_r       <= GRAVITY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_BODY_COUNT:   body_count_r <= cfg_data[CNT_W-1:0];
        REG_SOFTENING_SQ: soft_r       <= cfg_data;
        REG_GRAVITY:      grav_r       <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Body store.
  assign mem_we    = (state_r == ST_IDLE) && accept && (in_action == ACT_LOAD) &&
                     (32'(in_body_index) < MAX_BODIES);
  assign mem_waddr = AW'(in_body_index);
  assign mem_wdata = '{mass: in_mass, pos_x: in_pos_x, pos_y: in_pos_y, pos_z: in_pos_z};

  sga_body_mem #(.DEPTH(MAX_BODIES), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  sga_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  sga_isqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .x_in  ({s_r, {SQRT_SHIFT{1'b0}}}),
    .done  (sqrt_done),
    .root  (root)
  );

  sga_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({mul_p, {NUM_SHIFT{1'b0}}}),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (quo)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (accept && (in_action == ACT_QUERY)) state_nxt = ST_LOAD_I;
      ST_LOAD_I:    state_nxt = (n_lim == '0) ? ST_FIN_ISSUE : ST_READ_J;
      ST_READ_J:    state_nxt = ST_LOAD_J;
      ST_LOAD_J:    state_nxt = ST_SQ_ISSUE;
      ST_SQ_ISSUE:  state_nxt = ST_SQ_ACC;
      ST_SQ_ACC:    state_nxt = (ax_r == 2'd2) ? ST_SUM_S : ST_SQ_ISSUE;
      ST_SUM_S:     state_nxt = ST_SQRT_GO;
      ST_SQRT_GO:   state_nxt = (s_r == '0) ? ST_NEXT : ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (sqrt_done) state_nxt = ST_DEN_ISSUE;
      ST_DEN_ISSUE: state_nxt = ST_DEN_ACC;
      ST_DEN_ACC:   state_nxt = (k_r == 2'd1) ? ST_NUM_ISSUE : ST_DEN_ISSUE;
      ST_NUM_ISSUE: state_nxt = ST_DIV_GO;
      ST_DIV_GO:    state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_done) state_nxt = (ax_r == 2'd2) ? ST_NEXT : ST_NUM_ISSUE;
      ST_NEXT:      state_nxt = (j_r + CNT_W'(1) == n_lim) ? ST_FIN_ISSUE : ST_READ_J;
      ST_FIN_ISSUE: state_nxt = ST_FIN_ACC;
      ST_FIN_ACC:   state_nxt = (k_r == 2'd2) ? ST_FIN_SAT : ST_FIN_ISSUE;
      ST_FIN_SAT:   state_nxt = (ax_r == 2'd2) ? ST_DONE : ST_FIN_ISSUE;
      ST_DONE:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs decoded from the state.
  always_comb begin
    busy       = (state_r != ST_IDLE);
    out_valid  = (state_r == ST_DONE);
    sqrt_start = (state_r == ST_SQRT_GO) && (s_r != '0);
    div_start  = (state_r == ST_DIV_GO);
    mem_raddr  = (state_r == ST_IDLE) ? AW'(in_body_index) : AW'(j_r);
    mul_a      = '0;
    mul_b      = '0;
    case (state_r)
      ST_SQ_ISSUE: begin
        mul_a = mag_r[ax_r];
        mul_b = mag_r[ax_r];
      end
      ST_DEN_ISSUE: begin
        mul_a = (k_r == 2'd0) ? s_r[WORD_W-1:0] : WORD_W'(s_r[S_W-1:WORD_W]);
        mul_b = root;
      end
      ST_NUM_ISSUE: begin
        mul_a = mass_r;
        mul_b = mag_r[ax_r];
      end
      ST_FIN_ISSUE: begin
        case (k_r)
          2'd0:    mul_a = fmag[WORD_W-1:0];
          2'd1:    mul_a = fmag[2*WORD_W-1:WORD_W];
          default: mul_a = WORD_W'(fmag[ACC_W-1:2*WORD_W]);
        endcase
        mul_b = grav_r;
      end
      default: ;
    endcase
  end

  // Datapath updates.
  always_comb begin
    logic [WORD_W-1:0]   pj [3];
    logic [WORD_W:0]     r;
    logic [VAL_W-1:0]    v, limit;
    logic [OUT_W-1:0]    val;
    logic                over;
    j_nxt     = j_r;
    ax_nxt    = ax_r;
    k_nxt     = k_r;
    idx_nxt   = idx_r;
    mass_nxt  = mass_r;
    sumsq_nxt = sumsq_r;
    s_nxt     = s_r;
    den_nxt   = den_r;
    prod_nxt  = prod_r;
    sat_nxt   = sat_r;
    pi_nxt    = pi_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    pj[0]     = mem_rdata.pos_x;
    pj[1]     = mem_rdata.pos_y;
    pj[2]     = mem_rdata.pos_z;
    r         = '0;
    v         = prod_r[PROD_W-1:PROD_W-VAL_W];
    limit     = fneg ? LIMIT_NEG : LIMIT_POS;
    over      = v > limit;
    val       = over ? limit[OUT_W-1:0] : v[OUT_W-1:0];
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_action == ACT_QUERY)) begin
          idx_nxt = in_body_index;
          sat_nxt = 1'b0;
        end
      end
      // Own position; an index beyond the store sits at the origin.
      ST_LOAD_I: begin
        for (int a = 0; a < 3; a++) begin
          pi_nxt[a]  = idx_in_store ? pj[a] : '0;
          acc_nxt[a] = '0;
        end
        j_nxt    = '0;
        ax_nxt   = '0;
        k_nxt    = '0;
        prod_nxt = '0;
      end
      // Separation per axis as magnitude and sign.
      ST_LOAD_J: begin
        for (int a = 0; a < 3; a++) begin
          r          = {pj[a][WORD_W-1], pj[a]} - {pi_r[a][WORD_W-1], pi_r[a]};
          neg_nxt[a] = r[WORD_W];
          mag_nxt[a] = r[WORD_W] ? WORD_W'(~r + 33'd1) : r[WORD_W-1:0];
        end
        mass_nxt  = mem_rdata.mass;
        sumsq_nxt = '0;
        ax_nxt    = '0;
      end
      ST_SQ_ACC: begin
        sumsq_nxt = sumsq_r + SUMSQ_W'(mul_p);
        ax_nxt    = (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
      end
      ST_SUM_S: begin
        s_nxt = sumsq_r[SUMSQ_W-1:SUM_SHIFT] + S_W'(soft_r);
      end
      ST_SQRT_WAIT: begin
        k_nxt   = '0;
        den_nxt = '0;
      end
      // Denominator S * Q from two partial products.
      ST_DEN_ACC: begin
        den_nxt = (k_r == 2'd0) ? den_r + DEN_W'(mul_p)
                                : den_r + DEN_W'({mul_p, {WORD_W{1'b0}}});
        k_nxt   = k_r + 2'd1;
        ax_nxt  = '0;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          acc_nxt[ax_r] = neg_r[ax_r] ? acc_r[ax_r] - ACC_W'(quo)
                                      : acc_r[ax_r] + ACC_W'(quo);
          ax_nxt        = (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
        end
      end
      ST_NEXT: begin
        j_nxt    = j_r + CNT_W'(1);
        ax_nxt   = '0;
        k_nxt    = '0;
        prod_nxt = '0;
      end
      // Scale by gravity in three slices of 32, 32 and 8 bits.
      ST_FIN_ACC: begin
        case (k_r)
          2'd0:    prod_nxt = prod_r + PROD_W'(mul_p);
          2'd1:    prod_nxt = prod_r + PROD_W'({mul_p, {WORD_W{1'b0}}});
          default: prod_nxt = prod_r + PROD_W'({mul_p, {(2*WORD_W){1'b0}}});
        endcase
        k_nxt = k_r + 2'd1;
      end
      // Clamp, restore the sign and move to the next axis.
      ST_FIN_SAT: begin
        res_nxt[ax_r] = fneg ? (~val + OUT_W'(1)) : val;
        sat_nxt       = sat_r | over;
        prod_nxt      = '0;
        k_nxt         = '0;
        ax_nxt        = (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    j_r     <= j_nxt;
    ax_r    <= ax_nxt;
    k_r     <= k_nxt;
    idx_r   <= idx_nxt;
    mass_r  <= mass_nxt;
    sumsq_r <= sumsq_nxt;
    s_r     <= s_nxt;
    den_r   <= den_nxt;
    prod_r  <= prod_nxt;
    sat_r   <= sat_nxt;
    pi_r    <= pi_nxt;
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    acc_r   <= acc_nxt;
    res_r   <= res_nxt;
  end

  assign out_result_index = idx_r;
  assign out_acc_x        = res_r[0];
  assign out_acc_y        = res_r[1];
  assign out_acc_z        = res_r[2];
  assign out_saturated    = sat_r;

  // A load item never makes the block busy.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action == ACT_LOAD) |=> !busy)
    else $error("load item raised busy");

  // A query item makes the block busy in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action == ACT_QUERY) |=> busy)
    else $error("query item not taken up");

  // A result strobe lasts one cycle and leaves the block ready.
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe held or block stuck");

  // The divider only finishes while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV_WAIT))
    else $error("divider finished out of sequence");

endmodule

// ===== rtl/sga_body_mem.sv =====
// Body store: one record of mass and position per entry.
// One write port and one registered read port. Depends on sga_pkg.
module sga_body_mem import sga_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  body_t         wr_data,
  input  logic [AW-1:0] rd_addr,
  output body_t         rd_data
);

  body_t mem [DEPTH];
  body_t rd_data_r;

  // Write on load, read every cycle into the output register.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/sga_mul.sv =====
// Shared 32 x 32 unsigned multiplier with a registered product.
// Depends on sga_pkg.
module sga_mul import sga_pkg::*; (
  input  logic                clk,
  input  logic [WORD_W-1:0]   a,
  input  logic [WORD_W-1:0]   b,
  output logic [2*WORD_W-1:0] p
);

  logic [2*WORD_W-1:0] p_r;

  // Product appears in the cycle after the operands.
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

// ===== rtl/sga_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on sga_pkg.
module sga_isqrt import sga_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [ROOT_IN_W-1:0] x_in,
  output logic                 done,
  output logic [Q_W-1:0]       root
);

  localparam logic [ROOT_IN_W-1:0] BIT_INIT = {2'b01, {(ROOT_IN_W-2){1'b0}}};

  logic [ROOT_IN_W-1:0] x_r, x_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic                 run_r, run_nxt, done_r, done_nxt;
  logic [ROOT_IN_W:0]   trial;
  logic                 ge;

  assign trial = {1'b0, res_r} + {1'b0, bit_r};
  assign ge    = {1'b0, x_r} >= trial;

  // One digit-pair step per cycle.
  always_comb begin
    x_nxt    = x_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt   = x_in;
      res_nxt = '0;
      bit_nxt = BIT_INIT;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (ge) begin
        x_nxt   = x_r - trial[ROOT_IN_W-1:0];
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    x_r   <= x_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign root = res_r[Q_W-1:0];

endmodule

// ===== rtl/sga_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// The quotient of a pair term always stays below 2^60. Depends on sga_pkg.
module sga_div import sga_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] sh_r, sh_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             run_r, run_nxt, done_r, done_nxt;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  assign trial = {rem_r, sh_r[QUO_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  // Shift in one dividend bit, subtract when it fits, shift in the quotient bit.
  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = DEN_W'(dividend[NUM_W-1:QUO_W]);
      sh_nxt  = dividend[QUO_W-1:0];
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sh_nxt  = {sh_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(QUO_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = sh_r;

endmodule

// ===== tb/sga_accel_checker.sv =====
// Checker for the softened gravity accelerator: mirrors the body store and registers,
// predicts each query's acceleration and compares it with the result port.
// Depends on sga_pkg for widths, action codes and register indexes.
`timescale 1ns / 100ps
module sga_accel_checker import sga_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     in_action,
  input  logic [IDX_W-1:0]         in_body_index,
  input  logic [WORD_W-1:0]        in_mass,
  input  logic signed [WORD_W-1:0] in_pos_x,
  input  logic signed [WORD_W-1:0] in_pos_y,
  input  logic signed [WORD_W-1:0] in_pos_z,
  input  logic                     out_valid,
  input  logic [IDX_W-1:0]         out_result_index,
  input  logic signed [OUT_W-1:0]  out_acc_x,
  input  logic signed [OUT_W-1:0]  out_acc_y,
  input  logic signed [OUT_W-1:0]  out_acc_z,
  input  logic                     out_saturated,
  input  logic                     cfg_wr_en,
  input  logic [1:0]               cfg_index,
  input  logic [WORD_W-1:0]        cfg_data,
  output int                       fail_count,
  output int                       pending
);

  localparam int STORE_DEPTH = 1024;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [OUT_W-1:0] ax;
    logic [OUT_W-1:0] ay;
    logic [OUT_W-1:0] az;
    logic             sat;
  } accel_t;

  // Mirror of the body store and the registers.
  logic [WORD_W-1:0] body_mass [STORE_DEPTH];
  logic [WORD_W-1:0] body_pos  [3][STORE_DEPTH];
  logic [CNT_W-1:0]  count_r;
  logic [WORD_W-1:0] soft_r;
  logic [WORD_W-1:0] grav_r;

  accel_t accel_q[$];
  int     fails;

  initial begin
    fail_count = 0;
    pending    = 0;
    fails      = 0;
  end

  // Integer square root, one result bit per step.
  function automatic logic [63:0] root64(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] probe;
    res   = '0;
    probe = 64'd1 << 62;
    while (probe > x) probe = probe >> 2;
    while (probe != 0) begin
      if (x >= res + probe) begin
        x   = x - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // Scales a summed component by gravity, then clamps it to 48 bits.
  function automatic logic [OUT_W-1:0] scale_clamp(input logic signed [127:0] sum,
                                                   inout logic sat);
    logic         neg;
    logic [127:0] mag;
    logic [127:0] val;
    logic [127:0] lim;
    neg = sum < 0;
    mag = neg ? -sum : sum;
    val = (mag * 128'(grav_r)) >> 16;
    lim = neg ? 128'(48'h8000_0000_0000) : 128'(48'h7FFF_FFFF_FFFF);
    if (val > lim) begin
      val = lim;
      sat = 1'b1;
    end
    return neg ? OUT_W'(-val) : OUT_W'(val);
  endfunction

  // Direct sum of softened pair forces on body i over the first bodies.
  function automatic accel_t predict_accel(input logic [IDX_W-1:0] i);
    accel_t               res;
    logic signed [127:0]  acc [3];
    longint               d [3];
    logic [63:0]          m [3];
    logic [127:0]         sumsq, s, q, den, num, t;
    int                   n;
    for (int a = 0; a < 3; a++) acc[a] = '0;
    n = (count_r > STORE_DEPTH) ? STORE_DEPTH : int'(count_r);
    for (int j = 0; j < n; j++) begin
      sumsq = '0;
      for (int a = 0; a < 3; a++) begin
        d[a]  = longint'($signed(body_pos[a][j])) - longint'($signed(body_pos[a][i]));
        m[a]  = (d[a] < 0) ? 64'(-d[a]) : 64'(d[a]);
        sumsq = sumsq + 128'(m[a]) * 128'(m[a]);
      end
      s = (sumsq >> 16) + 128'(soft_r);
      // Coincident bodies with no softening contribute nothing.
      if (s == 0) continue;
      q   = 128'(root64(64'(s << 14)));
      den = s * q;
      for (int a = 0; a < 3; a++) begin
        num    = (128'(body_mass[j]) * 128'(m[a])) << 23;
        t      = num / den;
        acc[a] = (d[a] < 0) ? acc[a] - $signed(t) : acc[a] + $signed(t);
      end
    end
    res.idx = i;
    res.sat = 1'b0;
    res.ax  = scale_clamp(acc[0], res.sat);
    res.ay  = scale_clamp(acc[1], res.sat);
    res.az  = scale_clamp(acc[2], res.sat);
    return res;
  endfunction

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    accel_t want;
    if (!rst_n) begin
      count_r = BODY_COUNT_RST;
      soft_r  = SOFTENING_SQ_RST;
      grav_r  = GRAVITY_RST;
    end else begin
      // Compare a result with the oldest outstanding query.
      if (out_valid) begin
        if (accel_q.size() == 0) begin
          $error("result for body %0d with no query outstanding", out_result_index);
          fails++;
        end else begin
          want = accel_q.pop_front();
          if (out_result_index !== want.idx) begin
            $error("result_index: expected %0d, actual %0d", want.idx, out_result_index);
            fails++;
          end
          if (out_acc_x !== want.ax) begin
            $error("acc_x: expected %h, actual %h", want.ax, out_acc_x);
            fails++;
          end
          if (out_acc_y !== want.ay) begin
            $error("acc_y: expected %h, actual %h", want.ay, out_acc_y);
            fails++;
          end
          if (out_acc_z !== want.az) begin
            $error("acc_z: expected %h, actual %h", want.az, out_acc_z);
            fails++;
          end
          if (out_saturated !== want.sat) begin
            $error("saturated: expected %0b, actual %0b", want.sat, out_saturated);
            fails++;
          end
        end
      end
      // Register writes; an unused index changes nothing.
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_BODY_COUNT:   count_r = cfg_data[CNT_W-1:0];
          REG_SOFTENING_SQ: soft_r  = cfg_data;
          REG_GRAVITY:      grav_r  = cfg_data;
          default: ;
        endcase
      end
      // Accepted item: a load updates the store, a query is predicted.
      if (start && !busy) begin
        if (in_action == ACT_LOAD) begin
          body_mass[in_body_index]   = in_mass;
          body_pos[0][in_body_index] = in_pos_x;
          body_pos[1][in_body_index] = in_pos_y;
          body_pos[2][in_body_index] = in_pos_z;
        end else begin
          accel_q.insert(accel_q.size(), predict_accel(in_body_index));
        end
      end
    end
    fail_count <= fails;
    pending    <= accel_q.size();
  end

endmodule

// ===== tb/tb_softened_gravity_accel.sv =====
// Testbench top for the softened gravity accelerator: drives load and query items
// and register writes, and gives the verdict from the checker's failure count.
// Depends on sga_pkg, softened_gravity_accel and sga_accel_checker.
`timescale 1ns / 100ps
module tb_softened_gravity_accel;
  import sga_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int         SETTLE_CYCLES = 30;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_action = ACT_LOAD;
  logic [IDX_W-1:0]         in_body_index = '0;
  logic [WORD_W-1:0]        in_mass = '0;
  logic signed [WORD_W-1:0] in_pos_x = '0;
  logic signed [WORD_W-1:0] in_pos_y = '0;
  logic signed [WORD_W-1:0] in_pos_z = '0;
  logic                     out_valid;
  logic [IDX_W-1:0]         out_result_index;
  logic signed [OUT_W-1:0]  out_acc_x;
  logic signed [OUT_W-1:0]  out_acc_y;
  logic signed [OUT_W-1:0]  out_acc_z;
  logic                     out_saturated;
  logic                     cfg_wr_en = 1'b0;
  logic [1:0]               cfg_index = '0;
  logic [WORD_W-1:0]        cfg_data = '0;
  int                       fail_count;
  int                       pending;
  bit                       idle_on = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  softened_gravity_accel u_dut (.*);

  sga_accel_checker u_checker (.*);

  // Present one item, hold it until accepted, then maybe leave a gap.
  task automatic issue_item(input logic act, input logic [IDX_W-1:0] idx,
                            input logic [WORD_W-1:0] m, input logic [WORD_W-1:0] x,
                            input logic [WORD_W-1:0] y, input logic [WORD_W-1:0] z);
    start         <= 1'b1;
    in_action     <= act;
    in_body_index <= idx;
    in_mass       <= m;
    in_pos_x      <= x;
    in_pos_y      <= y;
    in_pos_z      <= z;
    do @(posedge clk); while (busy);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic query(input logic [IDX_W-1:0] idx);
    issue_item(ACT_QUERY, idx, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Random body: positions clustered at a random scale, masses spread widely.
  task automatic load_random(input logic [IDX_W-1:0] idx);
    issue_item(ACT_LOAD, idx, $urandom >> $urandom_range(0, 24),
               $signed($urandom) >>> $urandom_range(0, 16),
               $signed($urandom) >>> $urandom_range(0, 16),
               $signed($urandom) >>> $urandom_range(0, 16));
  endtask

  // Wait until every query has returned and the block is idle.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [WORD_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [WORD_W-1:0] soft_v, grav_v;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, coincident bodies without softening.
    write_reg(REG_SOFTENING_SQ, '0);
    write_reg(REG_BODY_COUNT, 11'd4);
    issue_item(ACT_LOAD, 10'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    issue_item(ACT_LOAD, 10'd1, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    issue_item(ACT_LOAD, 10'd2, 32'd1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    issue_item(ACT_LOAD, 10'd3, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
               32'h0003_0000);
    issue_item(ACT_LOAD, 10'd1023, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000);
    query(10'd0);
    query(10'd1);
    query(10'd2);
    query(10'd3);
    // The queried body lies outside the summed range here.
    query(10'd1023);
    settle();
    // Zero count sums nothing; an unused register index is ignored.
    write_reg(REG_BODY_COUNT, '0);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    query(10'd0);
    settle();
    write_reg(REG_BODY_COUNT, 11'd2);
    write_reg(REG_GRAVITY, 32'hFFFF_FFFF);
    query(10'd0);
    query(10'd1023);
    settle();
    write_reg(REG_GRAVITY, '0);
    query(10'd1);
    settle();

    // Load a small cluster, then sum over it with the largest softening.
    for (int j = 0; j < 16; j++) load_random(IDX_W'(j));
    settle();
    write_reg(REG_BODY_COUNT, 11'd16);
    write_reg(REG_SOFTENING_SQ, 32'hFFFF_FFFF);
    write_reg(REG_GRAVITY, GRAVITY_RST);
    query(IDX_W'($urandom_range(0, 15)));
    settle();

    // Random phases with small counts and assorted register settings.
    // Queries only name bodies that have been loaded.
    for (int p = 0; p < 9; p++) begin
      idle_on = (p < 7);
      case ($urandom_range(0, 3))
        0: soft_v = '0;
        1: soft_v = SOFTENING_SQ_RST;
        2: soft_v = $urandom;
        default: soft_v = '1;
      endcase
      case ($urandom_range(0, 3))
        0: grav_v = '0;
        1: grav_v = GRAVITY_RST;
        2: grav_v = $urandom;
        default: grav_v = '1;
      endcase
      write_reg(REG_BODY_COUNT, (p == 0) ? 11'd0 : CNT_W'($urandom_range(1, 8)));
      write_reg(REG_SOFTENING_SQ, soft_v);
      write_reg(REG_GRAVITY, grav_v);
      for (int k = 0; k < 60; k++) begin
        if ($urandom_range(0, 9) < 6) begin
          query(($urandom_range(0, 9) == 0) ? 10'd1023 : IDX_W'($urandom_range(0, 15)));
        end else if ($urandom_range(0, 1) == 0) begin
          load_random(IDX_W'($urandom_range(0, 15)));
        end else begin
          load_random(IDX_W'($urandom));
        end
      end
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("softened_gravity_accel test passed");
    end else begin
      $display("softened_gravity_accel test failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20_000_000;
    $display("softened_gravity_accel test failed");
    $finish;
  end

endmodule
